// ----- src/utf8ct_pkg.sv -----
// Shared types, constants and the Cyrillic transliteration table for the
// UTF-8 Cyrillic transliterator. No dependencies.
package utf8ct_pkg;

   localparam logic [7:0] LEAD_LOW      = 8'hD0;
   localparam logic [7:0] LEAD_HIGH     = 8'hD1;
   localparam logic [7:0] MAX_LEN_RESET = 8'd32;
   localparam logic [6:0] CHAR_QMARK    = 7'h3F;
   localparam logic [6:0] CHAR_SPACE    = 7'h20;
   localparam logic [6:0] CHAR_TILDE    = 7'h7E;
   localparam logic [6:0] LOWER_BIT     = 7'h20;

   localparam logic [10:0] CP_BASE_D0   = 11'h400;
   localparam logic [10:0] CP_BASE_D1   = 11'h440;
   localparam logic [10:0] CP_OFFSET    = 11'h080;
   localparam logic [10:0] CP_UPPER_LO  = 11'h410;
   localparam logic [10:0] CP_LOWER_LO  = 11'h430;
   localparam logic [10:0] CP_LOWER_HI  = 11'h44F;
   localparam logic [10:0] CP_IO_UPPER  = 11'h401;
   localparam logic [10:0] CP_IO_LOWER  = 11'h451;
   localparam logic [4:0]  IDX_IE       = 5'd5;

   // queue between classifier and output sequencer
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      LEAD_NONE = 2'd0,
      LEAD_D0   = 2'd1,
      LEAD_D1   = 2'd2
   } lead_type;

   // 0..3 characters produced by one input byte
   typedef struct packed {
      logic [1:0] num;
      logic [6:0] c0;
      logic [6:0] c1;
      logic [6:0] c2;
   } char_group_type;

   function automatic char_group_type mk_group(input logic [1:0] num,
                                               input logic [7:0] a,
                                               input logic [7:0] b,
                                               input logic [7:0] c);
      char_group_type res;
      res.num = num;
      res.c0  = a[6:0];
      res.c1  = b[6:0];
      res.c2  = c[6:0];
      return res;
   endfunction

   // Upper-case Cyrillic, index = code point - 0x410 (mod 32)
   function automatic char_group_type translit_lookup(input logic [4:0] idx);
      char_group_type res;
      case (idx)
         5'd0:    res = mk_group(2'd1, "A", 8'd0, 8'd0);
         5'd1:    res = mk_group(2'd1, "B", 8'd0, 8'd0);
         5'd2:    res = mk_group(2'd1, "V", 8'd0, 8'd0);
         5'd3:    res = mk_group(2'd1, "G", 8'd0, 8'd0);
         5'd4:    res = mk_group(2'd1, "D", 8'd0, 8'd0);
         5'd5:    res = mk_group(2'd1, "E", 8'd0, 8'd0);
         5'd6:    res = mk_group(2'd2, "Z", "h", 8'd0);
         5'd7:    res = mk_group(2'd1, "Z", 8'd0, 8'd0);
         5'd8:    res = mk_group(2'd1, "I", 8'd0, 8'd0);
         5'd9:    res = mk_group(2'd1, "Y", 8'd0, 8'd0);
         5'd10:   res = mk_group(2'd1, "K", 8'd0, 8'd0);
         5'd11:   res = mk_group(2'd1, "L", 8'd0, 8'd0);
         5'd12:   res = mk_group(2'd1, "M", 8'd0, 8'd0);
         5'd13:   res = mk_group(2'd1, "N", 8'd0, 8'd0);
         5'd14:   res = mk_group(2'd1, "O", 8'd0, 8'd0);
         5'd15:   res = mk_group(2'd1, "P", 8'd0, 8'd0);
         5'd16:   res = mk_group(2'd1, "R", 8'd0, 8'd0);
         5'd17:   res = mk_group(2'd1, "S", 8'd0, 8'd0);
         5'd18:   res = mk_group(2'd1, "T", 8'd0, 8'd0);
         5'd19:   res = mk_group(2'd1, "U", 8'd0, 8'd0);
         5'd20:   res = mk_group(2'd1, "F", 8'd0, 8'd0);
         5'd21:   res = mk_group(2'd2, "K", "h", 8'd0);
         5'd22:   res = mk_group(2'd2, "T", "s", 8'd0);
         5'd23:   res = mk_group(2'd2, "C", "h", 8'd0);
         5'd24:   res = mk_group(2'd2, "S", "h", 8'd0);
         5'd25:   res = mk_group(2'd3, "S", "c", "h");
         5'd26:   res = mk_group(2'd0, 8'd0, 8'd0, 8'd0);
         5'd27:   res = mk_group(2'd1, "Y", 8'd0, 8'd0);
         5'd28:   res = mk_group(2'd0, 8'd0, 8'd0, 8'd0);
         5'd29:   res = mk_group(2'd1, "E", 8'd0, 8'd0);
         5'd30:   res = mk_group(2'd2, "Y", "u", 8'd0);
         5'd31:   res = mk_group(2'd2, "Y", "a", 8'd0);
         default: res = mk_group(2'd0, 8'd0, 8'd0, 8'd0);
      endcase
      return res;
   endfunction

endpackage

// ----- src/utf8_cyrillic_transliterator_top.sv -----
// UTF-8 Cyrillic to Latin transliterator, top level.
// Depends on utf8ct_pkg, utf8ct_front, utf8ct_fifo and utf8ct_back.
//
// Accepts one UTF-8 byte per transaction and emits 0 to 3 printable ASCII
// characters for it; run_last marks the last character of a byte. A byte is
// taken every cycle while the four-entry group queue has room; the output side
// emits one character per cycle while rsp_ready is high, so a byte costs as
// many output transactions as characters it yields, and bytes that yield
// nothing (lead bytes, hard/soft signs, bytes past max_len) are not queued.
// The first character of a byte passes through the group queue and the
// sequencer's holding register before rsp_valid rises. csr_wr_data sets
// max_len (reset 32); write it only while the block is idle.
module utf8_cyrillic_transliterator_top import utf8ct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_text_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_run_last
);

   logic           push;
   char_group_type push_data;
   logic           full;
   logic           pop;
   char_group_type pop_data;
   logic           empty;

   utf8ct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_byte     (req_in_byte),
      .text_end    (req_text_end),
      .queue_full  (full),
      .push        (push),
      .push_data   (push_data)
   );

   utf8ct_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   utf8ct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_char    (rsp_out_char),
      .run_last    (rsp_run_last)
   );

endmodule

// ----- src/utf8ct_front.sv -----
// Classifier: takes input bytes, tracks lead byte and per-text count, builds
// the truncated character group for each byte. Depends on utf8ct_pkg.
module utf8ct_front import utf8ct_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_byte,
   input  logic           text_end,
   input  logic           queue_full,
   output logic           push,
   output char_group_type push_data
);

   logic [7:0]     max_len_ff, max_len_in;
   logic [7:0]     count_ff, count_in;
   lead_type       lead_ff, lead_in;
   logic           accept;
   logic           limit_hit;
   logic [10:0]    cp;
   logic [7:0]     room;
   char_group_type raw;
   char_group_type looked;
   logic [1:0]     n_out;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && in_ready;
   assign limit_hit = count_ff >= max_len_ff;
   assign room      = max_len_ff - count_ff;
   assign cp        = ((lead_ff == LEAD_D1) ? CP_BASE_D1 : CP_BASE_D0)
                      + {3'b000, in_byte} - CP_OFFSET;

   always_comb begin
      looked = mk_group(2'd1, {1'b0, CHAR_QMARK}, 8'd0, 8'd0);
      if (cp >= CP_UPPER_LO && cp <= CP_LOWER_HI) begin
         // bit 4 flips because the table starts at 0x410
         looked = translit_lookup({~cp[4], cp[3:0]});
         if (cp >= CP_LOWER_LO && looked.num != 2'd0) begin
            looked.c0 = looked.c0 | LOWER_BIT;
         end
      end else if (cp == CP_IO_UPPER || cp == CP_IO_LOWER) begin
         looked = translit_lookup(IDX_IE);
         if (cp == CP_IO_LOWER) begin
            looked.c0 = looked.c0 | LOWER_BIT;
         end
      end
   end

   always_comb begin
      raw     = mk_group(2'd0, 8'd0, 8'd0, 8'd0);
      lead_in = LEAD_NONE;
      if (limit_hit) begin
         raw = mk_group(2'd0, 8'd0, 8'd0, 8'd0);
      end else if (lead_ff != LEAD_NONE) begin
         raw = looked;
      end else if (!in_byte[7]) begin
         if (in_byte[6:0] >= CHAR_SPACE && in_byte[6:0] <= CHAR_TILDE) begin
            raw = mk_group(2'd1, in_byte, 8'd0, 8'd0);
         end else begin
            raw = mk_group(2'd1, {1'b0, CHAR_QMARK}, 8'd0, 8'd0);
         end
      end else if ((in_byte == LEAD_LOW || in_byte == LEAD_HIGH) && !text_end) begin
         lead_in = (in_byte == LEAD_LOW) ? LEAD_D0 : LEAD_D1;
      end else begin
         raw = mk_group(2'd1, {1'b0, CHAR_QMARK}, 8'd0, 8'd0);
      end
      if (text_end) begin
         lead_in = LEAD_NONE;
      end
   end

   // cut the group at the remaining room of this text
   assign n_out    = (room < {6'b0, raw.num}) ? room[1:0] : raw.num;
   assign count_in = text_end ? 8'd0 : count_ff + {6'b0, n_out};
   assign max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;

   assign push      = accept && (n_out != 2'd0);
   always_comb begin
      push_data     = raw;
      push_data.num = n_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         count_ff   <= 8'd0;
         lead_ff    <= LEAD_NONE;
      end else begin
         max_len_ff <= max_len_in;
         if (accept) begin
            count_ff <= count_in;
            lead_ff  <= lead_in;
         end
      end
   end

endmodule

// ----- src/utf8ct_fifo.sv -----
// Short queue of character groups between classifier and output sequencer.
// Depends on utf8ct_pkg.
module utf8ct_fifo import utf8ct_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  char_group_type push_data,
   output logic           full,
   input  logic           pop,
   output char_group_type pop_data,
   output logic           empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   char_group_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_FULL;
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

endmodule

// ----- src/utf8ct_back.sv -----
// Output sequencer: holds one character group and emits its characters one
// transaction at a time, flagging the last. Depends on utf8ct_pkg.
module utf8ct_back import utf8ct_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           queue_empty,
   input  char_group_type queue_data,
   output logic           pop,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [6:0]     out_char,
   output logic           run_last
);

   char_group_type cur_ff;
   logic           cur_valid_ff;
   logic [1:0]     idx_ff;
   logic           done;

   assign out_valid = cur_valid_ff;
   assign run_last  = (idx_ff + 2'd1) == cur_ff.num;
   assign done      = cur_valid_ff && out_ready && run_last;
   assign pop       = !queue_empty && (!cur_valid_ff || done);

   always_comb begin
      case (idx_ff)
         2'd0:    out_char = cur_ff.c0;
         2'd1:    out_char = cur_ff.c1;
         2'd2:    out_char = cur_ff.c2;
         default: out_char = cur_ff.c0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= queue_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (done) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= 2'd0;
         end else if (cur_valid_ff && out_ready) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

endmodule

// ----- src/utf8ct_checker.sv -----
// Port-level checks for the transliterator top, bound to it below.
// Depends only on the top level's ports.
module utf8ct_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_char,
   input logic       rsp_run_last
);

   logic [1:0] run_ff;

   // characters delivered since the last run_last
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         run_ff <= rsp_run_last ? 2'd0 : ((run_ff == 2'd3) ? 2'd3 : run_ff + 2'd1);
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                 && $stable(rsp_run_last))
      else $error("rsp transaction dropped or changed while stalled");

   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_char >= 7'd32 && rsp_out_char <= 7'd126)
      else $error("non-printable character emitted");

   a_run_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_ff == 2'd2 |-> rsp_run_last)
      else $error("more than three characters for one byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind utf8_cyrillic_transliterator_top utf8ct_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_char (rsp_out_char),
   .rsp_run_last (rsp_run_last)
);

// ----- tb/sv/tb_utf8_cyrillic_transliterator_top.sv -----
`timescale 1ns / 100ps
// Testbench for utf8_cyrillic_transliterator_top: a directed byte table, then random
// UTF-8 texts under several max_len settings, checked against an in-bench predictor.
// Depends on utf8ct_pkg and the transliterator RTL.
module tb_utf8_cyrillic_transliterator_top;
   import utf8ct_pkg::*;

   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 16;
   localparam int         PHASE_BYTES    = 27;
   localparam int         DIR_N          = 25;
   localparam logic [7:0] ASCII_END      = 8'h80;
   localparam logic [7:0] CONT_LO        = 8'h80;
   localparam logic [7:0] CONT_HI        = 8'hBF;
   localparam logic [7:0] D1_CONT_HI     = 8'h9F;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } disp_char_type;

   typedef struct packed {
      logic [7:0] b;
      logic       e;
      logic       typed;   // expected char given in the row
      logic       n;       // typed rows yield at most one char
      logic [6:0] ch;
   } dir_row_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_type;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       csr_wr_en    = 1'b0;
   logic [7:0] csr_wr_data  = 8'd0;
   logic       req_valid    = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte  = 8'd0;
   logic       req_text_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready    = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_run_last;

   // predictor state
   lead_type   p_lead;
   logic [7:0] p_count;
   logic [7:0] p_max_len;
   int         pred_n;
   logic [6:0] pred_ch [3];

   disp_char_type exp_chars [$];
   disp_char_type want;
   dir_row_type   dir_tab [DIR_N];
   int            errors        = 0;
   int            bytes_sent    = 0;
   int            chars_checked = 0;
   int            idle_cycles   = 0;
   int            burst_left    = 0;
   rx_mode_type   rx_mode       = RX_OPEN;
   int            rx_left       = 0;
   int            rx_run        = 0;
   logic          rx_hold       = 1'b0;

   always #4 clock = ~clock;

   utf8_cyrillic_transliterator_top u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_text_end (req_text_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

   // Latin spelling of upper-case Cyrillic U+0410 + idx, right aligned, zero padded
   function automatic logic [23:0] cyr_latin(input logic [4:0] idx);
      logic [23:0] w;
      case (idx)
         5'd0:  w = "A";    5'd1:  w = "B";    5'd2:  w = "V";    5'd3:  w = "G";
         5'd4:  w = "D";    5'd5:  w = "E";    5'd6:  w = "Zh";   5'd7:  w = "Z";
         5'd8:  w = "I";    5'd9:  w = "Y";    5'd10: w = "K";    5'd11: w = "L";
         5'd12: w = "M";    5'd13: w = "N";    5'd14: w = "O";    5'd15: w = "P";
         5'd16: w = "R";    5'd17: w = "S";    5'd18: w = "T";    5'd19: w = "U";
         5'd20: w = "F";    5'd21: w = "Kh";   5'd22: w = "Ts";   5'd23: w = "Ch";
         5'd24: w = "Sh";   5'd25: w = "Sch";  5'd26: w = 24'd0;  5'd27: w = "Y";
         5'd28: w = 24'd0;  5'd29: w = "E";    5'd30: w = "Yu";   default: w = "Ya";
      endcase
      return w;
   endfunction

   function automatic dir_row_type mk_row(input logic [7:0] b, input logic e,
                                          input logic typed, input logic n,
                                          input logic [7:0] ch);
      dir_row_type r;
      r.b     = b;
      r.e     = e;
      r.typed = typed;
      r.n     = n;
      r.ch    = ch[6:0];
      return r;
   endfunction

   task automatic emit_char(input logic [6:0] c);
      if (pred_n < 3 && p_count < p_max_len) begin
         pred_ch[pred_n] = c;
         pred_n++;
         p_count++;
      end
   endtask

   task automatic emit_codepoint(input logic [10:0] cp);
      logic [23:0] word;
      logic [7:0]  c;
      logic        known;
      int          n;
      known = 1'b1;
      word  = 24'd0;
      if (cp >= CP_UPPER_LO && cp <= CP_LOWER_HI)
         word = cyr_latin(5'(cp - CP_UPPER_LO));
      else if (cp == CP_IO_UPPER || cp == CP_IO_LOWER)
         word = cyr_latin(IDX_IE);
      else
         known = 1'b0;
      if (!known) begin
         emit_char(CHAR_QMARK);
      end else begin
         n = (word[23:16] != 8'd0) ? 3 : (word[15:8] != 8'd0) ? 2 : (word[7:0] != 8'd0) ? 1 : 0;
         for (int i = 0; i < n; i++) begin
            c = word[8 * (n - 1 - i) +: 8];
            if (i == 0 && cp >= CP_LOWER_LO)
               c[6:0] = c[6:0] | LOWER_BIT;
            emit_char(c[6:0]);
         end
      end
   endtask

   // chars caused by one byte; fills pred_n / pred_ch and advances the state
   task automatic transliterate_byte(input logic [7:0] b, input logic e);
      logic [10:0] base;
      pred_n = 0;
      if (p_count >= p_max_len) begin
         p_lead = LEAD_NONE;
      end else if (p_lead != LEAD_NONE) begin
         base   = (p_lead == LEAD_D0) ? CP_BASE_D0 : CP_BASE_D1;
         p_lead = LEAD_NONE;
         emit_codepoint(base + {3'b000, b} - CP_OFFSET);
      end else if (b < ASCII_END) begin
         emit_char((b[6:0] >= CHAR_SPACE && b[6:0] <= CHAR_TILDE) ? b[6:0] : CHAR_QMARK);
      end else if ((b == LEAD_LOW || b == LEAD_HIGH) && !e) begin
         p_lead = (b == LEAD_LOW) ? LEAD_D0 : LEAD_D1;
      end else begin
         emit_char(CHAR_QMARK);
      end
      if (e) begin
         p_count = 8'd0;
         p_lead  = LEAD_NONE;
      end
   endtask

   // one request transaction; called right after a rising edge
   task automatic send_byte(input logic [7:0] b, input logic e, input logic predicted);
      int            gap;
      disp_char_type dc;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid    <= 1'b1;
      req_in_byte  <= b;
      req_text_end <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
      transliterate_byte(b, e);
      if (predicted) begin
         for (int i = 0; i < pred_n; i++) begin
            dc.ch   = pred_ch[i];
            dc.last = (i == pred_n - 1);
            exp_chars.push_back(dc);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (exp_chars.size() != 0) @(posedge clock);
      // bytes that yield nothing may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [7:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      p_max_len  = v;
      burst_left = 0;
   endtask

   // mostly well-formed Cyrillic/ASCII tokens, some noise and broken sequences
   task automatic send_text(input logic close);
      logic [7:0] text [$];
      logic [7:0] lead;
      int         ntok;
      ntok = $urandom_range(1, 10);
      repeat (ntok) begin
         lead = ($urandom_range(0, 1) == 0) ? LEAD_LOW : LEAD_HIGH;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               text.push_back(lead);
               if (lead == LEAD_LOW)
                  text.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
               else
                  text.push_back(8'($urandom_range(CONT_LO, D1_CONT_HI)));
            end
            4, 5, 6: text.push_back(8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
            7:       text.push_back(8'($urandom_range(0, 255)));
            8: begin
               text.push_back(lead);
               text.push_back(8'($urandom_range(0, 255)));
            end
            default: text.push_back(8'($urandom_range(0, 127)));
         endcase
      end
      if ($urandom_range(0, 7) == 0)
         text.push_back(($urandom_range(0, 1) == 0) ? LEAD_LOW : LEAD_HIGH);
      foreach (text[i])
         send_byte(text[i], close && (i == text.size() - 1), 1'b1);
   endtask

   // an open text at the end of a phase carries across the max_len write
   task automatic run_phase(input logic [7:0] v);
      int start;
      write_max_len(v);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES)
         send_text((bytes_sent - start < PHASE_BYTES - 12) || ($urandom_range(0, 1) == 1));
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (rx_run == 0) begin
               rx_hold = ~rx_hold;
               rx_run  = $urandom_range(1, 8);
            end
            rx_run--;
            rsp_ready <= rx_hold;
         end
      endcase
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (exp_chars.size() == 0) begin
               $display("%0t: unexpected char: expected none, actual char=%h last=%b",
                        $time, rsp_out_char, rsp_run_last);
               errors++;
            end else begin
               want = exp_chars.pop_front();
               chars_checked++;
               if (rsp_out_char !== want.ch) begin
                  $display("%0t: out_char mismatch: expected %h, actual %h",
                           $time, want.ch, rsp_out_char);
                  errors++;
               end
               if (rsp_run_last !== want.last) begin
                  $display("%0t: run_last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_run_last);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d chars outstanding", $time, exp_chars.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      disp_char_type dc;
      p_lead    = LEAD_NONE;
      p_count   = 8'd0;
      p_max_len = MAX_LEN_RESET;

      dir_tab[0]  = mk_row(8'h41,     1'b0, 1'b1, 1'b1, "A");
      dir_tab[1]  = mk_row(8'h20,     1'b0, 1'b1, 1'b1, " ");
      dir_tab[2]  = mk_row(8'h7E,     1'b0, 1'b1, 1'b1, "~");
      dir_tab[3]  = mk_row(8'h00,     1'b0, 1'b1, 1'b1, "?");
      dir_tab[4]  = mk_row(8'h1F,     1'b0, 1'b1, 1'b1, "?");
      dir_tab[5]  = mk_row(8'h7F,     1'b0, 1'b1, 1'b1, "?");
      dir_tab[6]  = mk_row(8'h80,     1'b0, 1'b1, 1'b1, "?");
      dir_tab[7]  = mk_row(8'hFF,     1'b0, 1'b1, 1'b1, "?");
      dir_tab[8]  = mk_row(LEAD_LOW,  1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[9]  = mk_row(8'h90,     1'b0, 1'b0, 1'b0, 8'd0);
      dir_tab[10] = mk_row(LEAD_LOW,  1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[11] = mk_row(8'hA9,     1'b0, 1'b0, 1'b0, 8'd0);
      dir_tab[12] = mk_row(LEAD_HIGH, 1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[13] = mk_row(8'h89,     1'b0, 1'b0, 1'b0, 8'd0);
      // hard and soft signs
      dir_tab[14] = mk_row(LEAD_LOW,  1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[15] = mk_row(8'hAA,     1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[16] = mk_row(LEAD_HIGH, 1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[17] = mk_row(8'h8C,     1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[18] = mk_row(LEAD_LOW,  1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[19] = mk_row(8'h81,     1'b0, 1'b0, 1'b0, 8'd0);
      dir_tab[20] = mk_row(LEAD_HIGH, 1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[21] = mk_row(8'h91,     1'b0, 1'b0, 1'b0, 8'd0);
      // code point outside the table, then a lead byte closing the text
      dir_tab[22] = mk_row(LEAD_LOW,  1'b0, 1'b1, 1'b0, 8'd0);
      dir_tab[23] = mk_row(8'h00,     1'b0, 1'b1, 1'b1, "?");
      dir_tab[24] = mk_row(LEAD_HIGH, 1'b1, 1'b1, 1'b1, "?");

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         send_byte(dir_tab[i].b, dir_tab[i].e, !dir_tab[i].typed);
         if (dir_tab[i].typed && dir_tab[i].n) begin
            dc.ch   = dir_tab[i].ch;
            dc.last = 1'b1;
            exp_chars.push_back(dc);
         end
      end

      run_phase(8'd255);
      run_phase(8'd0);
      run_phase(8'd1);
      run_phase(8'd2);
      run_phase(8'd3);
      run_phase(8'($urandom_range(4, 40)));
      run_phase(8'd7);
      run_phase(MAX_LEN_RESET);

      drain_results();
      $display("Covered %0d bytes: directed table plus random texts at max_len 255, 0, 1, 2,",
               bytes_sent);
      $display("3, one random length, 7 and 32; checked %0d display chars, %0d errors.",
               chars_checked, errors);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
